>>> sv/pkvt_pkg.sv
package pkvt_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int KEY_BITS    = 32;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W       = $clog2(TABLE_DEPTH);

	localparam logic [1:0] OP_INSERT   = 2'd0;
	localparam logic [1:0] OP_LOOKUP   = 2'd1;
	localparam logic [1:0] OP_DELETE   = 2'd2;
	localparam logic [1:0] OP_RESERVED = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_ZERO = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] key;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value_out;
		logic [5:0]  entries_used;
	} rsp_t;

	// Broadcast from the top level to every cell.
	typedef struct packed {
		logic                ins;
		logic                del;
		logic [KEY_BITS-1:0] key;
		logic [31:0]         value;
	} cell_ctrl_t;

	// Status rippled from one cell to the next.
	typedef struct packed {
		logic occupied;
		logic hit;
	} cell_chain_t;

endpackage

>>> sv/packed_key_value_table.sv
// Channel   Direction  Beat    Handshake
// req       in         req_t   req_valid / req_stall
// rsp       out        rsp_t   rsp_valid / rsp_stall
//
// Accepting a request loads the request register; once the response
// register is free, every cell runs its compare and shift and the
// response register loads. Reset clears every slot and the entry count.
// A request is taken while a response waits, but its work holds back until
// the response register is free, so a stalled response stalls req as well.
module packed_key_value_table (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  pkvt_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output pkvt_pkg::rsp_t  rsp
);
	import pkvt_pkg::*;

	// The table is a row of cells, one per slot. Occupied slots always form
	// a prefix, so each cell learns from its left neighbor whether it is the
	// first empty slot (the insert target) and whether an earlier slot
	// already matched (only the first match answers, and on a delete every
	// cell from that point on takes its right neighbor's contents).

	logic                busy_q;
	req_t                req_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;
	logic [CNT_W-1:0]    used_count_q;

	logic                work;
	logic                key_nz;
	logic                full;
	logic                any_hit;
	logic [31:0]         found_value;
	cell_ctrl_t          ctrl;
	rsp_t                rsp_d;
	logic [CNT_W-1:0]    count_d;

	cell_chain_t         chain [TABLE_DEPTH+1];
	logic [KEY_BITS-1:0] cell_key [TABLE_DEPTH];
	logic [31:0]         cell_value [TABLE_DEPTH];
	logic [31:0]         cell_hit_value [TABLE_DEPTH];

	// A request waits in req_q until the response register can take it.
	assign work      = busy_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = busy_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign key_nz = (KEY_BITS'(req_q.key) != '0);

	always_comb begin
		ctrl.key   = KEY_BITS'(req_q.key);
		ctrl.value = req_q.value;
		ctrl.ins   = work && key_nz && (req_q.req_type == OP_INSERT) && !full;
		ctrl.del   = work && key_nz && (req_q.req_type == OP_DELETE);
	end

	// Slot zero always has an occupied left neighbor, so an empty table
	// inserts there.
	assign chain[0].occupied = 1'b1;
	assign chain[0].hit      = 1'b0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic [KEY_BITS-1:0] nk;
		logic [31:0]         nv;

		if (i == TABLE_DEPTH - 1) begin : g_last
			// The last slot empties on a shift.
			assign nk = '0;
			assign nv = '0;
		end else begin : g_mid
			assign nk = cell_key[i+1];
			assign nv = cell_value[i+1];
		end

		pkvt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.nxt_key   (nk),
			.nxt_value (nv),
			.key_q     (cell_key[i]),
			.value_q   (cell_value[i]),
			.hit_value (cell_hit_value[i])
		);
	end

	assign full    = chain[TABLE_DEPTH].occupied;
	assign any_hit = chain[TABLE_DEPTH].hit;

	// At most one cell reports a first hit, so an OR collects its value.
	always_comb begin
		found_value = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			found_value = found_value | cell_hit_value[i];
		end
	end

	always_comb begin
		rsp_d.status    = ST_OK;
		rsp_d.value_out = '0;
		count_d         = used_count_q;
		if (req_q.req_type == OP_RESERVED) begin
			rsp_d.status = ST_OK;
		end else if (!key_nz) begin
			rsp_d.status = ST_ZERO;
		end else if (req_q.req_type == OP_INSERT) begin
			if (full) begin
				rsp_d.status = ST_FULL;
			end else begin
				count_d = used_count_q + CNT_W'(1);
			end
		end else if (!any_hit) begin
			rsp_d.status = ST_MISS;
		end else begin
			rsp_d.value_out = found_value;
			if (req_q.req_type == OP_DELETE) begin
				count_d = used_count_q - CNT_W'(1);
			end
		end
		rsp_d.entries_used = 6'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
			used_count_q <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				busy_q <= 1'b1;
			end else if (work) begin
				busy_q <= 1'b0;
			end
			if (work) begin
				rsp_valid_q  <= 1'b1;
				used_count_q <= count_d;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_q <= req;
		end
		if (work) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

>>> sv/pkvt_cell.sv
module pkvt_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pkvt_pkg::cell_ctrl_t          ctrl,
	input  pkvt_pkg::cell_chain_t         chain_in,
	output pkvt_pkg::cell_chain_t         chain_out,
	input  logic [pkvt_pkg::KEY_BITS-1:0] nxt_key,
	input  logic [31:0]                   nxt_value,
	output logic [pkvt_pkg::KEY_BITS-1:0] key_q,
	output logic [31:0]                   value_q,
	output logic [31:0]                   hit_value
);
	import pkvt_pkg::*;

	logic match;
	logic occupied;
	logic insert_here;
	logic hit_first;

	// Stored keys are never zero; a zero request key reaches here but never inserts or deletes.
	assign match       = (key_q == ctrl.key);
	assign occupied    = (key_q != '0);
	assign insert_here = !occupied && chain_in.occupied;

	assign hit_first          = match && !chain_in.hit;
	assign hit_value          = hit_first ? value_q : 32'd0;
	assign chain_out.hit      = chain_in.hit || match;
	assign chain_out.occupied = occupied;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			value_q <= '0;
		end else if (ctrl.ins && insert_here) begin
			key_q   <= ctrl.key;
			value_q <= ctrl.value;
		end else if (ctrl.del && chain_out.hit) begin
			// At or past the removed entry: take the neighbor's contents.
			key_q   <= nxt_key;
			value_q <= nxt_value;
		end
	end

endmodule
